// File: design/painter_depth_sort_unit_assert.svh
// Assertion macros used by the depth sort datapath.
`ifndef PAINTER_DEPTH_SORT_UNIT_ASSERT_SVH
`define PAINTER_DEPTH_SORT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PDS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pds_pkg.sv
`default_nettype none

package pds_pkg;

  localparam int MAX_FACES = 64;
  localparam int IDX_W     = $clog2(MAX_FACES);
  localparam int CNT_W     = $clog2(MAX_FACES + 1);

  localparam int COORD_W = 16;
  localparam int ID_W    = 6;
  localparam int KEY_W   = 37;
  localparam int DIFF_W  = 19;
  localparam int MAG_W   = 18;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ENTRY_W = KEY_W + ID_W;

  localparam int N_COORDS    = 9;
  localparam int ID_OFS      = N_COORDS * COORD_W;
  localparam int IN_TDATA_W  = ((ID_OFS + ID_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ENTRY_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DROP,
    DP_MUL,
    DP_ACC,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_PUT_FIRST,
    DP_EMIT_RD,
    DP_EMIT_LD,
    DP_EMIT_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_face;
    logic less;
    logic ptr_zero;
    logic emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/pds_ctrl.sv
`default_nettype none

module pds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pds_pkg::dp_stat_t stat,
  output pds_pkg::dp_cmd_t       cmd
);
  import pds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY,
    S_SCAN_INIT,
    S_SCAN,
    S_PUT_FIRST,
    S_E_RD,
    S_E_LD,
    S_E_HOLD
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] step;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_E_HOLD);

  always_comb begin
    cmd.op     = DP_NOP;
    cmd.axis   = step;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.full) begin
            cmd.op     = DP_DROP;
            state_next = in_last ? S_E_RD : S_IDLE;
          end else begin
            cmd.op     = DP_LOAD;
            state_next = S_KEY;
          end
        end
      end
      S_KEY: begin
        if (step == AXIS_Z + 2'd1) begin
          cmd.op     = DP_ACC;
          state_next = stat.empty ? S_PUT_FIRST : S_SCAN_INIT;
        end else begin
          cmd.op = DP_MUL;
        end
      end
      S_SCAN_INIT: begin
        cmd.op     = DP_SCAN_INIT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (stat.less) begin
          state_next = stat.ptr_zero ? S_PUT_FIRST : S_SCAN;
        end else begin
          state_next = stat.last_face ? S_E_RD : S_IDLE;
        end
      end
      S_PUT_FIRST: begin
        cmd.op     = DP_PUT_FIRST;
        state_next = stat.last_face ? S_E_RD : S_IDLE;
      end
      S_E_RD: begin
        cmd.op     = DP_EMIT_RD;
        state_next = S_E_LD;
      end
      S_E_LD: begin
        cmd.op     = DP_EMIT_LD;
        state_next = S_E_HOLD;
      end
      S_E_HOLD: begin
        if (out_ready) begin
          cmd.op     = DP_EMIT_NEXT;
          state_next = stat.emit_last ? S_IDLE : S_E_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= AXIS_X;
    end else begin
      state <= state_next;
      if (state == S_KEY) begin
        step <= step + 2'd1;
      end else begin
        step <= AXIS_X;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/pds_dp.sv
`default_nettype none

`include "painter_depth_sort_unit_assert.svh"

module pds_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pds_pkg::COORD_W-1:0]      cfg_data,
  input  wire logic [pds_pkg::IN_TDATA_W-1:0]   in_data,
  input  wire logic                             in_last,
  input  wire pds_pkg::dp_cmd_t                 cmd,
  output pds_pkg::dp_stat_t                     stat,
  output logic [pds_pkg::ENTRY_W-1:0]           out_data,
  output logic                                  out_dropped,
  output logic                                  out_last
);
  import pds_pkg::*;

  function automatic logic [DIFF_W-1:0] sx(input logic [COORD_W-1:0] v);
    return {{(DIFF_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // |a + b + c - 3*cam|
  function automatic logic [MAG_W-1:0] axis_mag(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [COORD_W-1:0] c,
                                                input logic [COORD_W-1:0] cam);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] neg;
    logic [DIFF_W-1:0] cs;
    cs  = sx(cam);
    d   = sx(a) + sx(b) + sx(c) - cs - {cs[DIFF_W-2:0], 1'b0};
    neg = -d;
    return d[DIFF_W-1] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  logic [COORD_W-1:0] cam_x;
  logic [COORD_W-1:0] cam_y;
  logic [COORD_W-1:0] cam_z;

  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [MAG_W-1:0] mag_z;
  logic [MAG_W-1:0] mag_sel;
  logic [SQ_W-1:0]  sq;
  logic [SQ_W-1:0]  prod;
  logic [KEY_W-1:0] acc;
  logic [ID_W-1:0]  id_new;
  logic             last_new;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] count_inc;
  logic             overflow;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ecnt;

  logic [ENTRY_W-1:0] mem [MAX_FACES];
  logic [ENTRY_W-1:0] rd_q;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [ENTRY_W-1:0] wd;
  logic               re;
  logic [IDX_W-1:0]   ra;
  logic [ENTRY_W-1:0] new_entry;
  logic               less;
  logic               run_end;
  logic               put_first;

  function automatic logic [COORD_W-1:0] crd(input logic [IN_TDATA_W-1:0] v,
                                             input int i);
    return v[i*COORD_W +: COORD_W];
  endfunction

  assign cnt_m1    = count - CNT_W'(1);
  assign count_inc = count + CNT_W'(1);
  assign new_entry = {acc, id_new};
  assign less      = (rd_q[ENTRY_W-1:ID_W] < acc);
  assign run_end   = (cmd.op == DP_EMIT_NEXT) && out_last;
  assign put_first = (cmd.op == DP_PUT_FIRST);

  always_comb begin
    case (cmd.axis)
      AXIS_X:  mag_sel = mag_x;
      AXIS_Y:  mag_sel = mag_y;
      default: mag_sel = mag_z;
    endcase
  end

  assign sq = SQ_W'(mag_sel) * SQ_W'(mag_sel);

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = new_entry;
    re = 1'b0;
    ra = '0;
    case (cmd.op)
      DP_SCAN_INIT: begin
        re = 1'b1;
        ra = cnt_m1[IDX_W-1:0];
      end
      DP_SCAN: begin
        we = 1'b1;
        wa = ptr + IDX_W'(1);
        if (less) begin
          wd = rd_q;
          re = 1'b1;
          ra = ptr - IDX_W'(1);
        end
      end
      DP_PUT_FIRST: begin
        we = 1'b1;
      end
      DP_EMIT_RD: begin
        re = 1'b1;
        ra = ecnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAM_X: cam_x <= cfg_data;
        REG_CAM_Y: cam_y <= cfg_data;
        REG_CAM_Z: cam_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      ecnt     <= '0;
    end else begin
      case (cmd.op)
        DP_DROP: begin
          overflow <= 1'b1;
        end
        DP_SCAN: begin
          if (!less) begin
            count <= count + CNT_W'(1);
          end
        end
        DP_PUT_FIRST: begin
          count <= count + CNT_W'(1);
        end
        DP_EMIT_NEXT: begin
          if (out_last) begin
            count    <= '0;
            overflow <= 1'b0;
            ecnt     <= '0;
          end else begin
            ecnt <= ecnt + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        mag_x    <= axis_mag(crd(in_data, 0), crd(in_data, 3), crd(in_data, 6), cam_x);
        mag_y    <= axis_mag(crd(in_data, 1), crd(in_data, 4), crd(in_data, 7), cam_y);
        mag_z    <= axis_mag(crd(in_data, 2), crd(in_data, 5), crd(in_data, 8), cam_z);
        id_new   <= in_data[ID_OFS +: ID_W];
        last_new <= in_last;
        acc      <= '0;
        prod     <= '0;
      end
      DP_MUL: begin
        prod <= sq;
        acc  <= acc + KEY_W'(prod);
      end
      DP_ACC: begin
        acc <= acc + KEY_W'(prod);
      end
      DP_SCAN_INIT: begin
        ptr <= cnt_m1[IDX_W-1:0];
      end
      DP_SCAN: begin
        if (less) begin
          ptr <= ptr - IDX_W'(1);
        end
      end
      DP_EMIT_LD: begin
        out_data    <= rd_q;
        out_dropped <= overflow;
        out_last    <= (CNT_W'(ecnt) == cnt_m1);
      end
      default: begin
      end
    endcase
  end

  assign stat.full      = (count == CNT_W'(MAX_FACES));
  assign stat.empty     = (count == '0);
  assign stat.last_face = last_new;
  assign stat.less      = less;
  assign stat.ptr_zero  = (ptr == '0);
  assign stat.emit_last = out_last;

  `PDS_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CNT_W'(MAX_FACES), "count past capacity")
  `PDS_ASSERT_NEXT(a_run_clear, clk, rst, run_end, count == '0 && !overflow, "stale run state")
  `PDS_ASSERT_NEXT(a_put_count, clk, rst, put_first, count == $past(count_inc), "no count bump")

endmodule

`default_nettype wire

// File: design/painter_depth_sort_unit.sv
// Painter's-order depth sort. Each input beat carries one face (three signed
// Q8.8 vertices and an id); its key is nine times the squared camera-to-centroid
// distance, built axis by axis on one shared 18x18 multiplier, and the face
// is then inserted into a 64-entry store (one read and one write port) kept
// sorted farthest first (stable). Insertion walks the store one entry per cycle
// behind the registered read; a face arriving with the store full is dropped
// and flagged on tuser of every result of that run. On a face with tlast the
// stored faces stream out one at a time, each held until m_tready, the final
// one with m_tlast. Input is taken only while no face is being inserted or
// emitted. The store needs no clearing after reset.
`default_nettype none

module painter_depth_sort_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pds_pkg::COORD_W-1:0]      cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, face_id
  input  wire logic [pds_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  wire logic                             s_tlast,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // sorted_id, depth_key
  output logic [pds_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // dropped
  output logic                                  m_tuser,
  output logic                                  m_tlast
);
  import pds_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [ENTRY_W-1:0] out_data;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pds_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_data     (s_tdata),
    .in_last     (s_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data),
    .out_dropped (m_tuser),
    .out_last    (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W - ENTRY_W){1'b0}}, out_data};

endmodule

`default_nettype wire
